// ----- design/keypad_display_scanner_top_defines.svh -----
// Assertion macros shared by the checker of the keypad and display scanner.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef KEYPAD_DISPLAY_SCANNER_TOP_DEFINES_SVH
`define KEYPAD_DISPLAY_SCANNER_TOP_DEFINES_SVH

// Checked on every edge outside reset.
`define KDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define KDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/kds_pkg.sv -----
`timescale 1ns / 1ps

package kds_pkg;

  localparam int DIGITS         = 10;
  localparam int KEY_FIFO_DEPTH = 16;

  localparam int COL_W   = $clog2(DIGITS);
  localparam int PTR_W   = $clog2(KEY_FIFO_DEPTH);
  localparam int DIGIT_W = 4;
  localparam int SEG_W   = 8;
  localparam int KEY_W   = 5;
  localparam int CNT_W   = 8;

  localparam logic [SEG_W-1:0] BLANK_SEGMENTS = 8'hff;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COUNT = 1'b1;
  localparam logic [CNT_W-1:0]     RELEASE_COUNT_RST = 8'd4;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               row_n_pressed;
    logic               row_o_pressed;
    logic [DIGIT_W-1:0] write_digit;
    logic [SEG_W-1:0]   write_segments;
  } item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_select;
    logic [SEG_W-1:0]   segment_drive;
    logic               drive_valid;
    logic [KEY_W-1:0]   key_code;
    logic               key_valid;
  } result_t;

  // Key pushes raised by one scan tick, row N first.
  typedef struct packed {
    logic             push_n;
    logic [KEY_W-1:0] code_n;
    logic             push_o;
    logic [KEY_W-1:0] code_o;
  } push_req_t;

endpackage

// ----- design/kds_scan.sv -----
`timescale 1ns / 1ps

module kds_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic                          row_n_pressed,
  input  logic                          row_o_pressed,
  input  logic [kds_pkg::CNT_W-1:0]     release_count,
  input  logic                          write_en,
  input  logic [kds_pkg::DIGIT_W-1:0]   write_digit,
  input  logic [kds_pkg::SEG_W-1:0]     write_segments,
  output logic [kds_pkg::DIGIT_W-1:0]   digit_select,
  output logic [kds_pkg::SEG_W-1:0]     segment_drive,
  output kds_pkg::push_req_t            push_req
);

  localparam logic [kds_pkg::COL_W-1:0] LAST_COL = kds_pkg::COL_W'(kds_pkg::DIGITS - 1);

  logic [kds_pkg::COL_W-1:0] scan_position;
  logic [kds_pkg::COL_W-1:0] scan_position_next;
  logic [kds_pkg::SEG_W-1:0] frame_store [kds_pkg::DIGITS];
  logic [kds_pkg::CNT_W-1:0] cnt_n [kds_pkg::DIGITS];
  logic [kds_pkg::CNT_W-1:0] cnt_o [kds_pkg::DIGITS];
  logic [kds_pkg::CNT_W-1:0] cnt_n_next;
  logic [kds_pkg::CNT_W-1:0] cnt_o_next;
  logic [kds_pkg::CNT_W-1:0] load_n;
  logic [kds_pkg::CNT_W-1:0] load_o;
  logic                      write_hit;

  assign digit_select  = kds_pkg::DIGIT_W'(scan_position);
  assign segment_drive = frame_store[scan_position];

  // A press reloads the counter; a key is reported only when its counter had run out.
  always_comb begin
    load_n = row_n_pressed ? release_count : cnt_n[scan_position];
    load_o = row_o_pressed ? release_count : cnt_o[scan_position];
    cnt_n_next = (load_n != '0) ? load_n - 1'b1 : load_n;
    cnt_o_next = (load_o != '0) ? load_o - 1'b1 : load_o;

    push_req.push_n = tick && row_n_pressed && (cnt_n[scan_position] == '0);
    push_req.code_n = kds_pkg::KEY_W'(scan_position);
    push_req.push_o = tick && row_o_pressed && (cnt_o[scan_position] == '0);
    push_req.code_o = kds_pkg::KEY_W'(scan_position) + kds_pkg::KEY_W'(kds_pkg::DIGITS);

    scan_position_next = (scan_position == LAST_COL) ? '0 : scan_position + 1'b1;
    write_hit = write_en &&
                ({1'b0, write_digit} < (kds_pkg::DIGIT_W + 1)'(kds_pkg::DIGITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      for (int i = 0; i < kds_pkg::DIGITS; i++) begin
        frame_store[i] <= kds_pkg::BLANK_SEGMENTS;
        cnt_n[i]       <= '0;
        cnt_o[i]       <= '0;
      end
    end else begin
      if (tick) begin
        cnt_n[scan_position] <= cnt_n_next;
        cnt_o[scan_position] <= cnt_o_next;
        scan_position        <= scan_position_next;
      end
      if (write_hit) begin
        frame_store[write_digit[kds_pkg::COL_W-1:0]] <= write_segments;
      end
    end
  end

endmodule

// ----- design/kds_key_fifo.sv -----
`timescale 1ns / 1ps

module kds_key_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  kds_pkg::push_req_t          push_req,
  input  logic                        pop,
  output logic                        key_valid,
  output logic [kds_pkg::KEY_W-1:0]   key_code
);

  localparam logic [kds_pkg::PTR_W-1:0] LAST_PTR =
    kds_pkg::PTR_W'(kds_pkg::KEY_FIFO_DEPTH - 1);

  logic [kds_pkg::KEY_W-1:0] key_fifo [kds_pkg::KEY_FIFO_DEPTH];
  logic [kds_pkg::PTR_W-1:0] fifo_write_ptr;
  logic [kds_pkg::PTR_W-1:0] fifo_read_ptr;
  logic [kds_pkg::PTR_W-1:0] fifo_write_ptr_next;
  logic [kds_pkg::PTR_W-1:0] wp_inc;
  logic [kds_pkg::PTR_W-1:0] wa;
  logic [kds_pkg::PTR_W-1:0] wa_inc;
  logic                      do_n;
  logic                      do_o;

  function automatic logic [kds_pkg::PTR_W-1:0] ptr_inc(input logic [kds_pkg::PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // One slot stays empty, so a full ring is one where the next write slot is the read slot.
  // The row O push sees the ring as the row N push left it.
  always_comb begin
    wp_inc = ptr_inc(fifo_write_ptr);
    do_n   = push_req.push_n && (wp_inc != fifo_read_ptr);
    wa     = do_n ? wp_inc : fifo_write_ptr;
    wa_inc = ptr_inc(wa);
    do_o   = push_req.push_o && (wa_inc != fifo_read_ptr);
    fifo_write_ptr_next = do_o ? wa_inc : wa;
  end

  assign key_valid = (fifo_read_ptr != fifo_write_ptr);
  assign key_code  = key_fifo[fifo_read_ptr];

  always_ff @(posedge clk) begin
    if (do_n) begin
      key_fifo[fifo_write_ptr] <= push_req.code_n;
    end
    if (do_o) begin
      key_fifo[wa] <= push_req.code_o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_write_ptr <= '0;
      fifo_read_ptr  <= '0;
    end else begin
      fifo_write_ptr <= fifo_write_ptr_next;
      if (pop && key_valid) begin
        fifo_read_ptr <= ptr_inc(fifo_read_ptr);
      end
    end
  end

endmodule

// ----- design/keypad_display_scanner_top.sv -----
`timescale 1ns / 1ps
// A request waits in the request register; its result is registered once the result
// register is free. Throughput: one request per cycle while results are taken; the two
// registers let a new request enter while a result waits for result_ready.
// Reset (rst, synchronous): scanning off, release count 4, digit 0, all digits blank,
// key counters cleared and the key queue empty.

module keypad_display_scanner_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  kds_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output kds_pkg::result_t                  result,
  input  logic                              cfg_write,
  input  logic [kds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kds_pkg::CNT_W-1:0]         cfg_data
);

  logic                       scan_enable;
  logic [kds_pkg::CNT_W-1:0]  release_count;
  logic                       req_valid;
  kds_pkg::item_t             req;
  logic                       has_result;
  logic                       req_fire;
  logic                       out_free;
  logic                       tick;
  logic                       pop;
  logic                       write_en;
  logic [kds_pkg::DIGIT_W-1:0] digit_select;
  logic [kds_pkg::SEG_W-1:0]  segment_drive;
  logic                       key_valid;
  logic [kds_pkg::KEY_W-1:0]  key_code;
  kds_pkg::push_req_t         push_req;
  kds_pkg::result_t           result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enable   <= 1'b0;
      release_count <= kds_pkg::RELEASE_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        kds_pkg::CFG_SCAN_ENABLE:   scan_enable   <= cfg_data[0];
        kds_pkg::CFG_RELEASE_COUNT: release_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    has_result = 1'b0;
    case (kds_pkg::kind_t'(req.kind))
      kds_pkg::KIND_TICK:  has_result = scan_enable;
      kds_pkg::KIND_POP:   has_result = 1'b1;
      kds_pkg::KIND_WRITE: has_result = 1'b0;
      default:             has_result = 1'b0;
    endcase
  end

  // A request with no result retires without waiting on the result register.
  assign out_free   = !result_valid || result_ready;
  assign req_fire   = req_valid && (!has_result || out_free);
  assign item_ready = !req_valid || req_fire;

  assign tick     = req_fire && (req.kind == kds_pkg::KIND_TICK) && scan_enable;
  assign pop      = req_fire && (req.kind == kds_pkg::KIND_POP);
  assign write_en = req_fire && (req.kind == kds_pkg::KIND_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item_ready) begin
      req_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      req <= item;
    end
  end

  kds_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .row_n_pressed  (req.row_n_pressed),
    .row_o_pressed  (req.row_o_pressed),
    .release_count  (release_count),
    .write_en       (write_en),
    .write_digit    (req.write_digit),
    .write_segments (req.write_segments),
    .digit_select   (digit_select),
    .segment_drive  (segment_drive),
    .push_req       (push_req)
  );

  kds_key_fifo u_key_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_req  (push_req),
    .pop       (pop),
    .key_valid (key_valid),
    .key_code  (key_code)
  );

  always_comb begin
    result_next = '0;
    if (req.kind == kds_pkg::KIND_TICK) begin
      result_next.digit_select  = digit_select;
      result_next.segment_drive = segment_drive;
      result_next.drive_valid   = 1'b1;
    end else if (key_valid) begin
      result_next.key_code  = key_code;
      result_next.key_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (req_fire && has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && has_result) begin
      result <= result_next;
    end
  end

endmodule

// ----- design/kds_checker.sv -----
`timescale 1ns / 1ps
`include "keypad_display_scanner_top_defines.svh"

module kds_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input kds_pkg::result_t result
);

  // A waiting result must not move or vanish.
  `KDS_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

  `KDS_ASSERT(a_tick_fields, result_valid && result.drive_valid |-> !result.key_valid && result.key_code == '0 && result.digit_select < kds_pkg::DIGIT_W'(kds_pkg::DIGITS), "bad tick result")

  `KDS_ASSERT(a_pop_fields, result_valid && !result.drive_valid |-> result.digit_select == '0 && result.segment_drive == '0 && (result.key_valid || result.key_code == '0), "bad pop result")

  `KDS_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !result_valid, "result valid right after reset")

endmodule

bind keypad_display_scanner_top kds_checker u_kds_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import kds_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int NUM_KEYS       = 2 * DIGITS;
  localparam int SETTLE_CYCLES  = 4;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_REQUESTS = 70;
  localparam int HOLD_CYCLES    = 200;
  localparam int NUM_PHASES     = 5;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CNT_W-1:0]     reg_val;
    item_t                req;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  // Shadow copy of the scanner state.
  bit                   sim_scan_on;
  logic [CNT_W-1:0]     sim_release_load;
  int                   sim_digit;
  logic [SEG_W-1:0]     sim_frame [DIGITS];
  logic [CNT_W-1:0]     sim_release_cnt [NUM_KEYS];
  logic [KEY_W-1:0]     sim_key_queue [KEY_FIFO_DEPTH];
  int                   sim_wr;
  int                   sim_rd;

  result_t              expected_results [$];
  stim_row_t            directed_rows [$];
  int                   fail_count = 0;
  int                   cycle_count = 0;
  bit                   no_gaps = 1'b0;
  int                   ready_hold_cycles = 0;
  result_t              head_want;

  keypad_display_scanner_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void note_failure(input string what, input result_t want,
                                       input result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display({"%0t %s: expected dig=%0d seg=%h dv=%b key=%0d kv=%b,",
                " got dig=%0d seg=%h dv=%b key=%0d kv=%b"},
               $realtime, what, want.digit_select, want.segment_drive, want.drive_valid,
               want.key_code, want.key_valid, got.digit_select, got.segment_drive,
               got.drive_valid, got.key_code, got.key_valid);
  endfunction

  function automatic void reset_shadow();
    sim_scan_on      = 1'b0;
    sim_release_load = RELEASE_COUNT_RST;
    sim_digit        = 0;
    sim_wr           = 0;
    sim_rd           = 0;
    for (int i = 0; i < DIGITS; i++) sim_frame[i] = BLANK_SEGMENTS;
    for (int i = 0; i < NUM_KEYS; i++) sim_release_cnt[i] = '0;
  endfunction

  // A press reloads the release counter; the key is queued only when the
  // counter had already run out, and a full queue drops it.
  function automatic void debounce_key(input int code, input logic pressed);
    logic [CNT_W-1:0] cnt;
    int               nxt;
    cnt = sim_release_cnt[code];
    if (pressed) begin
      if (cnt == 0) begin
        nxt = (sim_wr + 1) % KEY_FIFO_DEPTH;
        if (nxt != sim_rd) begin
          sim_key_queue[sim_wr] = KEY_W'(code);
          sim_wr = nxt;
        end
      end
      cnt = sim_release_load;
    end
    if (cnt != 0) cnt--;
    sim_release_cnt[code] = cnt;
  endfunction

  function automatic bit predict_scan_result(input item_t req, output result_t res);
    int col;
    res = '0;
    if (req.kind == KIND_TICK) begin
      if (!sim_scan_on) return 1'b0;
      col = sim_digit;
      res.digit_select  = DIGIT_W'(col);
      res.segment_drive = sim_frame[col];
      res.drive_valid   = 1'b1;
      debounce_key(col, req.row_n_pressed);
      debounce_key(col + DIGITS, req.row_o_pressed);
      sim_digit = (col + 1) % DIGITS;
      return 1'b1;
    end
    if (req.kind == KIND_POP) begin
      if (sim_rd != sim_wr) begin
        res.key_code  = sim_key_queue[sim_rd];
        res.key_valid = 1'b1;
        sim_rd = (sim_rd + 1) % KEY_FIFO_DEPTH;
      end
      return 1'b1;
    end
    if (req.kind == KIND_WRITE && req.write_digit < DIGITS)
      sim_frame[req.write_digit] = req.write_segments;
    return 1'b0;
  endfunction

  function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CNT_W-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_req_row(input logic [1:0] kind, input logic n, input logic o,
                                      input logic [DIGIT_W-1:0] digit,
                                      input logic [SEG_W-1:0] seg,
                                      input bit typed, input result_t want);
    stim_row_t row;
    row = '{default: '0};
    row.req   = '{kind, n, o, digit, seg};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input item_t req, input bit typed, input result_t want);
    int      gap;
    result_t got;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (predict_scan_result(req, got)) expected_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SCAN_ENABLE) sim_scan_on = val[0];
    else sim_release_load = val;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        note_failure("unexpected result", '0, result);
      end else begin
        head_want = expected_results.pop_front();
        if (result.digit_select !== head_want.digit_select ||
            result.segment_drive !== head_want.segment_drive ||
            result.drive_valid !== head_want.drive_valid ||
            result.key_code !== head_want.key_code ||
            result.key_valid !== head_want.key_valid)
          note_failure("result mismatch", head_want, result);
      end
    end
  end

  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      if (ready_hold_cycles > 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles <= 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    bit               phase_en [NUM_PHASES];
    logic [CNT_W-1:0] phase_load [NUM_PHASES];
    item_t            req;
    int               done;
    int               pick;
    int               press_odds;
    bit               held_off;

    reset_shadow();
    phase_en   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_load = '{8'd1, 8'd255, CNT_W'($urandom_range(2, 12)), 8'd7, 8'd0};

    // Scanning is off after reset, so a tick is dropped.
    add_req_row(KIND_TICK, 1'b1, 1'b1, 4'd0, 8'h00, 1'b0, '0);
    add_req_row(KIND_POP, 1'b0, 1'b0, 4'd0, 8'h00, 1'b1, '0);
    add_req_row(KIND_UNUSED, 1'b1, 1'b1, 4'hf, 8'hff, 1'b0, '0);
    add_req_row(KIND_WRITE, 1'b0, 1'b0, 4'hf, 8'h00, 1'b0, '0);
    add_cfg_row(CFG_SCAN_ENABLE, 8'd1);
    add_req_row(KIND_TICK, 1'b0, 1'b0, 4'd0, 8'h00, 1'b1, '{4'd0, 8'hff, 1'b1, 5'd0, 1'b0});
    add_req_row(KIND_WRITE, 1'b1, 1'b1, 4'd9, 8'h00, 1'b0, '0);
    add_req_row(KIND_WRITE, 1'b0, 1'b0, 4'd1, 8'ha5, 1'b0, '0);
    add_req_row(KIND_TICK, 1'b1, 1'b0, 4'd0, 8'h00, 1'b1, '{4'd1, 8'ha5, 1'b1, 5'd0, 1'b0});
    add_req_row(KIND_TICK, 1'b0, 1'b1, 4'd0, 8'h00, 1'b1, '{4'd2, 8'hff, 1'b1, 5'd0, 1'b0});
    add_req_row(KIND_POP, 1'b0, 1'b0, 4'd0, 8'h00, 1'b1, '{4'd0, 8'h00, 1'b0, 5'd1, 1'b1});
    add_req_row(KIND_POP, 1'b0, 1'b0, 4'd0, 8'h00, 1'b1, '{4'd0, 8'h00, 1'b0, 5'd12, 1'b1});
    add_req_row(KIND_POP, 1'b0, 1'b0, 4'd0, 8'h00, 1'b1, '0);
    // With a zero reload every held key is queued on each pass; the sweep below
    // fills the key queue and the last push is dropped.
    add_cfg_row(CFG_RELEASE_COUNT, 8'd0);
    for (int d = 3; d < DIGITS - 1; d++)
      add_req_row(KIND_TICK, 1'b1, 1'b1, 4'd0, 8'h00, 1'b0, '0);
    add_req_row(KIND_TICK, 1'b1, 1'b1, 4'd0, 8'h00, 1'b1, '{4'd9, 8'h00, 1'b1, 5'd0, 1'b0});
    add_req_row(KIND_TICK, 1'b1, 1'b1, 4'd0, 8'h00, 1'b0, '0);
    add_req_row(KIND_POP, 1'b0, 1'b0, 4'd0, 8'h00, 1'b1, '{4'd0, 8'h00, 1'b0, 5'd3, 1'b1});

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_SCAN_ENABLE, CNT_W'(phase_en[p]));
      write_reg(CFG_RELEASE_COUNT, phase_load[p]);
      press_odds = $urandom_range(1, 4);
      held_off   = 1'b0;
      done       = 0;
      while (done < PHASE_REQUESTS) begin
        if (done % 32 == 0) no_gaps <= ($urandom_range(0, 3) == 0);
        // One long receiver stall while ticks keep coming fills the block.
        if (p == 0 && done == 30 && !held_off) begin
          ready_hold_cycles <= HOLD_CYCLES;
          held_off = 1'b1;
        end
        req = item_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) req.kind = KIND_TICK;
        else if (pick < 80) req.kind = KIND_POP;
        else if (pick < 95) req.kind = KIND_WRITE;
        else req.kind = KIND_UNUSED;
        if (req.kind == KIND_TICK) begin
          req.row_n_pressed = ($urandom_range(0, press_odds) == 0);
          req.row_o_pressed = ($urandom_range(0, press_odds) == 0);
        end
        if (req.kind == KIND_WRITE && $urandom_range(0, 5) != 0)
          req.write_digit = DIGIT_W'($urandom_range(0, DIGITS - 1));
        if (req.kind == KIND_POP || (req.kind == KIND_TICK && sim_scan_on) ||
            (req.kind == KIND_WRITE && req.write_digit < DIGITS))
          done++;
        send_request(req, 1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES * 2) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/kds_pkg.sv
design/kds_scan.sv
design/kds_key_fifo.sv
design/keypad_display_scanner_top.sv
design/kds_checker.sv
dv/testbench.sv
